// ===== rtl/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg
// Types, constants and character classes for the source line tokenizer.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int unsigned COL_W    = 8;
  localparam int unsigned LEN_W    = 8;
  localparam int unsigned LINE_W   = 16;
  localparam int unsigned Q_DEPTH  = 4;
  localparam int unsigned Q_PTR_W  = 2;
  localparam int unsigned Q_CNT_W  = 3;

  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
  localparam logic [LINE_W-1:0] LINE_MAX = '1;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_IDEN = 2'd2,
    MODE_NUM  = 2'd3
  } slt_mode_e;

  typedef enum logic [2:0] {
    KIND_STR  = 3'd0,
    KIND_IDEN = 3'd1,
    KIND_INT  = 3'd2,
    KIND_FLT  = 3'd3,
    KIND_OP   = 3'd4
  } slt_kind_e;

  typedef struct packed {
    slt_kind_e          kind;
    logic [LINE_W-1:0]  line;
    logic [COL_W-1:0]   start;
    logic [LEN_W-1:0]   len;
    logic               last;
  } slt_token_t;

  typedef struct packed {
    logic [1:0]  num;
    slt_token_t  tok0;
    slt_token_t  tok1;
  } slt_push_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
    logic               room;
  } slt_q_status_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    logic r;
    case (c)
      8'h23, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h2F, 8'h3F,
      8'h2B, 8'h2D, 8'h2A, 8'h3D, 8'h21, 8'h2C: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] len_inc(input logic [LEN_W-1:0] n);
    return (n == LEN_MAX) ? n : n + LEN_W'(1);
  endfunction

endpackage

// ===== rtl/slt_lexer.sv =====
// ----------------------------------------------------------------------------
// slt_lexer
// Lexing state and combinational classification of one transfer into up to
// two tokens.
// ----------------------------------------------------------------------------
module slt_lexer #(
  parameter int unsigned LINE_BYTES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        ch_i,
  input  logic              end_of_line_i,
  output slt_pkg::slt_push_t push_o
);
  import slt_pkg::*;

  localparam int unsigned ColLimInt = (LINE_BYTES - 1 < 255) ? LINE_BYTES - 1 : 255;
  localparam logic [COL_W-1:0] ColLimit = COL_W'(ColLimInt);

  slt_mode_e          mode_q, mode_d;
  logic [COL_W-1:0]   start_q, start_d;
  logic [LEN_W-1:0]   count_q, count_d;
  logic [COL_W-1:0]   column_q, column_d;
  logic               float_q, float_d;
  logic [LINE_W-1:0]  line_q, line_d;

  logic        flush_v, op_v, relex;
  slt_token_t  flush_t, op_t;
  logic [LEN_W-1:0] grown;
  slt_kind_e   num_kind;

  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    count_d  = count_q;
    column_d = column_q;
    float_d  = float_q;
    line_d   = line_q;
    flush_v  = 1'b0;
    op_v     = 1'b0;
    relex    = 1'b0;
    grown    = len_inc(count_q);
    num_kind = float_q ? KIND_FLT : KIND_INT;
    flush_t  = '{kind: KIND_IDEN, line: line_q, start: start_q, len: count_q, last: 1'b0};
    op_t     = '{kind: KIND_OP, line: line_q, start: column_q, len: LEN_W'(1), last: 1'b1};

    if (end_of_line_i) begin
      case (mode_q)
        MODE_IDEN: flush_v = 1'b1;
        MODE_NUM: begin
          flush_v      = 1'b1;
          flush_t.kind = num_kind;
        end
        default: flush_v = 1'b0;
      endcase
      mode_d   = MODE_IDLE;
      count_d  = '0;
      float_d  = 1'b0;
      column_d = '0;
      if (line_q != LINE_MAX) line_d = line_q + LINE_W'(1);
    end else begin
      case (mode_q)
        MODE_STR: begin
          count_d = grown;
          if (ch_i == CH_QUOTE) begin
            flush_v      = 1'b1;
            flush_t.kind = KIND_STR;
            flush_t.len  = grown;
            mode_d       = MODE_IDLE;
          end
        end
        MODE_IDEN: begin
          if (is_letter(ch_i) || is_digit(ch_i)) begin
            count_d = grown;
          end else begin
            flush_v = 1'b1;
            mode_d  = MODE_IDLE;
            relex   = 1'b1;
          end
        end
        MODE_NUM: begin
          if (is_digit(ch_i)) begin
            count_d = grown;
          end else if (ch_i == CH_DOT) begin
            count_d = grown;
            float_d = 1'b1;
          end else begin
            flush_v      = 1'b1;
            flush_t.kind = num_kind;
            mode_d       = MODE_IDLE;
            relex        = 1'b1;
          end
        end
        default: relex = 1'b1;
      endcase

      if (relex) begin
        if (ch_i == CH_QUOTE) begin
          mode_d  = MODE_STR;
          start_d = column_q;
          count_d = LEN_W'(1);
        end else if (is_letter(ch_i)) begin
          mode_d  = MODE_IDEN;
          start_d = column_q;
          count_d = LEN_W'(1);
        end else if (is_digit(ch_i)) begin
          mode_d  = MODE_NUM;
          start_d = column_q;
          count_d = LEN_W'(1);
          float_d = 1'b0;
        end else if (is_op(ch_i)) begin
          op_v = 1'b1;
        end
      end
      if (column_q < ColLimit) column_d = column_q + COL_W'(1);
    end

    flush_t.last = !op_v;
    push_o.num   = {1'b0, flush_v} + {1'b0, op_v};
    push_o.tok0  = flush_v ? flush_t : op_t;
    push_o.tok1  = op_t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      start_q  <= '0;
      count_q  <= '0;
      column_q <= '0;
      float_q  <= 1'b0;
      line_q   <= LINE_W'(1);
    end else if (take_i) begin
      mode_q   <= mode_d;
      start_q  <= start_d;
      count_q  <= count_d;
      column_q <= column_d;
      float_q  <= float_d;
      line_q   <= line_d;
    end
  end

endmodule

// ===== rtl/slt_out_queue.sv =====
// ----------------------------------------------------------------------------
// slt_out_queue
// Result queue: takes up to two tokens per cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
module slt_out_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_en_i,
  input  slt_pkg::slt_push_t     push_i,
  input  logic                   pop_i,
  output logic                   valid_o,
  output slt_pkg::slt_token_t    tok_o,
  output slt_pkg::slt_q_status_t status_o
);
  import slt_pkg::*;

  slt_token_t         mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic [Q_PTR_W-1:0] wr_next;
  logic [1:0]         n_push;

  assign n_push  = push_en_i ? push_i.num : 2'd0;
  assign wr_next = wr_q + Q_PTR_W'(1);
  assign wr_d    = wr_q + Q_PTR_W'(n_push);
  assign rd_d    = pop_i ? rd_q + Q_PTR_W'(1) : rd_q;
  assign cnt_d   = cnt_q + Q_CNT_W'(n_push) - Q_CNT_W'(pop_i);

  assign valid_o         = cnt_q != '0;
  assign tok_o           = mem_q[rd_q];
  assign status_o.count  = cnt_q;
  assign status_o.room   = cnt_q <= Q_CNT_W'(Q_DEPTH - 2);

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) mem_q[wr_q] <= push_i.tok0;
    if (n_push == 2'd2) mem_q[wr_next] <= push_i.tok1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/source_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_line_tokenizer
// Byte-wide lexer that emits token descriptors for a stream of source text.
// ----------------------------------------------------------------------------
// Input channel: one byte per transfer (ch_i), or an end-of-line marker
// (end_of_line_i set, ch_i ignored). Output channel: one token descriptor
// per transfer with kind, line, start column, length and last_of_run, which
// marks the final token caused by one input transfer.
// Tokens enter the result queue at the input transfer that produces them and
// are offered oldest first. Throughput: one input per cycle while in_ready_o
// is set, one token per cycle while out_ready_i is set; an input ending an
// identifier or number that is itself an operator yields two tokens, which
// leave one after the other. Tokens wait in a four-entry queue; the input is
// ready while at least two entries are free, so a stalled receiver holds the
// input back before the queue fills, and nothing is dropped.
// Reset: lexer idle, column 0, line 1, queue empty.
// ----------------------------------------------------------------------------
module source_line_tokenizer #(
  parameter int unsigned LINE_BYTES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  input  logic       end_of_line_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] token_kind_o,
  output logic [15:0] line_number_o,
  output logic [7:0] start_column_o,
  output logic [7:0] token_length_o,
  output logic       last_of_run_o
);
  import slt_pkg::*;

  logic          take;
  slt_push_t     push;
  slt_token_t    tok;
  slt_q_status_t q_status;

  assign in_ready_o = q_status.room;
  assign take       = in_valid_i && in_ready_o;

  slt_lexer #(
    .LINE_BYTES(LINE_BYTES)
  ) u_lexer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .ch_i         (ch_i),
    .end_of_line_i(end_of_line_i),
    .push_o       (push)
  );

  slt_out_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_en_i(take),
    .push_i   (push),
    .pop_i    (out_valid_o && out_ready_i),
    .valid_o  (out_valid_o),
    .tok_o    (tok),
    .status_o (q_status)
  );

  assign token_kind_o   = 3'(tok.kind);
  assign line_number_o  = tok.line;
  assign start_column_o = tok.start;
  assign token_length_o = tok.len;
  assign last_of_run_o  = tok.last;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.count <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue overflow");

  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_of_run_o) |=> out_valid_o)
    else $error("second token of a pair missing");

  a_two_needs_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && push.num == 2'd2) |-> (push.tok1.kind == KIND_OP && !end_of_line_i))
    else $error("two tokens without an operator");

endmodule

// ===== verif/slt_token_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_token_checker
// Watches both channels of the source line tokenizer and checks every token.
// Each byte or line-end transfer runs through a local lexer that tracks mode,
// token start, length, float flag, column and line. The tokens it predicts
// wait in order, and each token transfer is compared field by field with the
// oldest one.
// ----------------------------------------------------------------------------
module slt_token_checker #(
  parameter int unsigned LINE_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  ch_i,
  input  logic        end_of_line_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  token_kind_i,
  input  logic [15:0] line_number_i,
  input  logic [7:0]  start_column_i,
  input  logic [7:0]  token_length_i,
  input  logic        last_of_run_i,
  output int          errors_o,
  output int          pending_o,
  output int          bytes_seen_o,
  output int          tokens_seen_o
);
  import slt_pkg::*;

  localparam int unsigned COL_TOP = (LINE_BYTES - 1 < 255) ? LINE_BYTES - 1 : 255;

  slt_mode_e         lex_mode;
  logic [COL_W-1:0]  tok_start;
  logic [COL_W-1:0]  column;
  logic [LEN_W-1:0]  tok_len;
  logic              has_dot;
  logic [LINE_W-1:0] line_no;

  slt_token_t due_tokens[$];
  slt_token_t run_toks[2];
  int         run_n;

  function automatic logic alpha_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic numeral_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic operator_char(input logic [7:0] c);
    case (c)
      "#", "(", ")", "{", "}", "/", "?", "+", "-", "*", "=", "!", ",": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic emit(input slt_kind_e kind, input logic [COL_W-1:0] start,
                      input logic [LEN_W-1:0] len);
    slt_token_t t;
    t.kind  = kind;
    t.line  = line_no;
    t.start = start;
    t.len   = len;
    t.last  = 1'b0;
    run_toks[run_n] = t;
    run_n++;
  endtask

  task automatic grow_token();
    if (tok_len != LEN_MAX) tok_len++;
  endtask

  task automatic close_number();
    if (has_dot) begin
      emit(KIND_FLT, tok_start, tok_len);
    end else begin
      emit(KIND_INT, tok_start, tok_len);
    end
  endtask

  task automatic lex_fresh(input logic [7:0] c);
    if (c == CH_QUOTE) begin
      lex_mode  = MODE_STR;
      tok_start = column;
      tok_len   = 1;
    end else if (alpha_char(c)) begin
      lex_mode  = MODE_IDEN;
      tok_start = column;
      tok_len   = 1;
    end else if (numeral_char(c)) begin
      lex_mode  = MODE_NUM;
      tok_start = column;
      tok_len   = 1;
      has_dot   = 1'b0;
    end else if (operator_char(c)) begin
      emit(KIND_OP, column, 1);
    end
  endtask

  task automatic lex_input(input logic [7:0] c, input logic eol);
    slt_token_t t;
    run_n = 0;
    if (eol) begin
      if (lex_mode == MODE_IDEN) begin
        emit(KIND_IDEN, tok_start, tok_len);
      end else if (lex_mode == MODE_NUM) begin
        close_number();
      end
      lex_mode = MODE_IDLE;
      tok_len  = 0;
      has_dot  = 1'b0;
      column   = 0;
      if (line_no != LINE_MAX) line_no++;
    end else begin
      case (lex_mode)
        MODE_STR: begin
          grow_token();
          if (c == CH_QUOTE) begin
            emit(KIND_STR, tok_start, tok_len);
            lex_mode = MODE_IDLE;
          end
        end
        MODE_IDEN: begin
          if (alpha_char(c) || numeral_char(c)) begin
            grow_token();
          end else begin
            emit(KIND_IDEN, tok_start, tok_len);
            lex_mode = MODE_IDLE;
            lex_fresh(c);
          end
        end
        MODE_NUM: begin
          if (numeral_char(c)) begin
            grow_token();
          end else if (c == CH_DOT) begin
            has_dot = 1'b1;
            grow_token();
          end else begin
            close_number();
            lex_mode = MODE_IDLE;
            lex_fresh(c);
          end
        end
        default: lex_fresh(c);
      endcase
      if (column < COL_TOP) column++;
    end
    for (int i = 0; i < run_n; i++) begin
      t      = run_toks[i];
      t.last = (i == run_n - 1);
      due_tokens.push_back(t);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    slt_token_t want;
    slt_token_t got;
    if (!rst_ni) begin
      lex_mode      = MODE_IDLE;
      tok_start     = '0;
      tok_len       = '0;
      column        = '0;
      has_dot       = 1'b0;
      line_no       = 1;
      run_n         = 0;
      due_tokens.delete();
      errors_o      = 0;
      bytes_seen_o  = 0;
      tokens_seen_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        lex_input(ch_i, end_of_line_i);
        bytes_seen_o++;
      end
      if (out_valid_i && out_ready_i) begin
        got.kind  = slt_kind_e'(token_kind_i);
        got.line  = line_number_i;
        got.start = start_column_i;
        got.len   = token_length_i;
        got.last  = last_of_run_i;
        tokens_seen_o++;
        if (due_tokens.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: token with none expected: %s %0d line %0d col %0d len %0d last %0b",
                     $realtime, "kind", got.kind, got.line, got.start, got.len, got.last);
        end else begin
          want = due_tokens.pop_front();
          if (got.kind !== want.kind || got.line !== want.line || got.start !== want.start ||
              got.len !== want.len || got.last !== want.last) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("%0t: token %0d expected kind %0d line %0d col %0d len %0d last %0b,",
                       $realtime, tokens_seen_o, want.kind, want.line, want.start, want.len,
                       want.last);
              $display("    got kind %0d line %0d col %0d len %0d last %0b",
                       got.kind, got.line, got.start, got.len, got.last);
            end
          end
        end
      end
    end
    pending_o = due_tokens.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the source line tokenizer.
// Sends a short directed text, then random lines of identifiers, numbers,
// strings, operators and stray bytes, and two overlong lines. Both sides
// stall at random in the first two of three phases, neither in the third; a
// separate checker predicts every token.
// ----------------------------------------------------------------------------
module testbench;
  import slt_pkg::*;

  localparam int unsigned LINE_BYTES  = 256;
  localparam int          STALL_LIMIT = 1000;
  localparam logic [7:0]  SPACE       = 8'h20;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  ch_i;
  logic        end_of_line_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  token_kind_o;
  logic [15:0] line_number_o;
  logic [7:0]  start_column_o;
  logic [7:0]  token_length_o;
  logic        last_of_run_o;

  int errors;
  int pending;
  int bytes_seen;
  int tokens_seen;
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int items_sent   = 0;
  int quiet_cycles = 0;

  source_line_tokenizer #(
    .LINE_BYTES(LINE_BYTES)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .ch_i          (ch_i),
    .end_of_line_i (end_of_line_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .token_kind_o  (token_kind_o),
    .line_number_o (line_number_o),
    .start_column_o(start_column_o),
    .token_length_o(token_length_o),
    .last_of_run_o (last_of_run_o)
  );

  slt_token_checker #(
    .LINE_BYTES(LINE_BYTES)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .ch_i          (ch_i),
    .end_of_line_i (end_of_line_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .token_kind_i  (token_kind_o),
    .line_number_i (line_number_o),
    .start_column_i(start_column_o),
    .token_length_i(token_length_o),
    .last_of_run_i (last_of_run_o),
    .errors_o      (errors),
    .pending_o     (pending),
    .bytes_seen_o  (bytes_seen),
    .tokens_seen_o (tokens_seen)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(0, 1)) return 8'($urandom_range("a", "z"));
    return 8'($urandom_range("A", "Z"));
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'($urandom_range("0", "9"));
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 12))
      0: return "#";
      1: return "(";
      2: return ")";
      3: return "{";
      4: return "}";
      5: return "/";
      6: return "?";
      7: return "+";
      8: return "-";
      9: return "*";
      10: return "=";
      11: return "!";
      default: return ",";
    endcase
  endfunction

  function automatic logic [7:0] pick_text_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CH_QUOTE) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // call at a falling edge; returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] c, input logic eol);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    ch_i          <= c;
    end_of_line_i <= eol;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic send_line(input int shape);
    int n_tok;
    case (shape)
      1: begin
        send_byte(pick_letter(), 1'b0);
        repeat (289) send_byte($urandom_range(0, 1) ? pick_letter() : pick_digit(), 1'b0);
        send_byte(pick_operator(), 1'b0);
      end
      2: begin
        send_byte(CH_QUOTE, 1'b0);
        repeat (279) send_byte(pick_text_byte(), 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        repeat (3) send_byte(pick_digit(), 1'b0);
      end
      default: begin
        n_tok = $urandom_range(0, 10);
        repeat (n_tok) begin
          case ($urandom_range(0, 9))
            0, 1, 2: begin
              send_byte(pick_letter(), 1'b0);
              repeat ($urandom_range(0, 7))
                send_byte($urandom_range(0, 2) == 0 ? pick_digit() : pick_letter(), 1'b0);
            end
            3, 4: begin
              send_byte(pick_digit(), 1'b0);
              repeat ($urandom_range(0, 5))
                send_byte($urandom_range(0, 4) == 0 ? CH_DOT : pick_digit(), 1'b0);
            end
            5: begin
              send_byte(CH_QUOTE, 1'b0);
              repeat ($urandom_range(0, 6)) send_byte(pick_text_byte(), 1'b0);
              if ($urandom_range(0, 5) != 0) send_byte(CH_QUOTE, 1'b0);
            end
            6, 7: send_byte(pick_operator(), 1'b0);
            default: send_byte(8'($urandom_range(0, 255)), 1'b0);
          endcase
          if ($urandom_range(0, 1))
            send_byte($urandom_range(0, 2) == 0 ? 8'($urandom_range(0, 255)) : SPACE, 1'b0);
        end
      end
    endcase
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    ch_i          = 8'h00;
    end_of_line_i = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    in_idle_pct  = 13;
    out_idle_pct = 57;
    send_text("\"ab\"x1+9.5=7 q");
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    send_text("\"z");
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("Zz09 3.");
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    while (items_sent < 300) send_line(0);

    in_idle_pct  = 57;
    out_idle_pct = 13;
    send_line(1);
    while (items_sent < 680) send_line(0);

    in_idle_pct  = 0;
    out_idle_pct = 0;
    send_line(2);
    while (items_sent < 1050) send_line(0);
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d input transfers: directed text, random lines and two overlong",
             bytes_seen);
    $display("lines under three stall patterns; %0d tokens checked.", tokens_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
